>>> design/cscan_pkg.sv
// cscan_pkg: shared types and constants of the c-scan disk scheduler
// item structs for both channels, the queue entry and default parameter values
// no dependencies
package cscan_pkg;

    // fixed field widths of the channels
    localparam int FIELD_W = 16;
    localparam int SEEK_W  = 17;
    localparam int CFG_W   = 17;

    // parameter defaults
    localparam int DEF_MAX_REQUESTS = 32;
    localparam int DEF_TRACK_BITS   = 16;

    // command queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_W-1:0] TRACK_COUNT_RESET = 17'h10000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] request_track;
        logic [FIELD_W-1:0] head_position;
        logic [FIELD_W-1:0] previous_position;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] served_track;
        logic [SEEK_W-1:0]  total_seek;
        logic               is_last;
        logic               is_empty;
        logic               overflowed;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] track;
        logic [FIELD_W-1:0] head;
        logic [FIELD_W-1:0] prev;
    } t_q_entry;

endpackage

>>> design/cscan_disk_scheduler.sv
// cscan_disk_scheduler: top level of the c-scan disk request scheduler
// holds the track count register and joins the front end to the back end
// depends on cscan_pkg, cscan_front, cscan_back
//
// Load items (cmd 0) queue request tracks into a store of MAX_REQUESTS
// entries; a load beyond capacity is dropped and the overflow flag is shown
// on every result of the next run. A start item (cmd 1) gives the head and
// previous head positions and the block emits every stored request in c-scan
// order: moving up (previous < head) it serves tracks at or above the head
// ascending, runs to the top track, wraps to track 0 and serves the rest
// ascending; otherwise the mirror order. The last result carries the total
// seek (the wrap jump not counted) and is_last; a start with an empty store
// gives one result with is_empty and is_last. Tracks, head and previous
// position above top = min(track_count, 2^TRACK_BITS) - 1 saturate to top,
// and a track_count of 0 acts as 1. Timing: input items enter a four-entry
// command queue, so up to four items are taken while the back end is busy.
// Loads drain at one per cycle while no run is in progress. Each result of
// a run is one pass over the store through its single registered read
// port (a read per stored request, the registered read, then the commit of
// the pick), plus any time the result register waits on i_out_stall.
// Write track_count only while no run is pending.
module cscan_disk_scheduler #(
    parameter int MAX_REQUESTS = cscan_pkg::DEF_MAX_REQUESTS,
    parameter int TRACK_BITS   = cscan_pkg::DEF_TRACK_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input item channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  cscan_pkg::t_in_item          i_in_item,
    // result item channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output cscan_pkg::t_out_item         o_out_item,
    // track_count register write
    input  logic                         i_cfg_we,
    input  logic [cscan_pkg::CFG_W-1:0]  i_cfg_data
);

    logic [cscan_pkg::CFG_W-1:0] r_track_count;

    // command queue handshake
    logic                q_valid;
    logic                q_pop;
    cscan_pkg::t_q_entry q_entry;

    // track count, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= cscan_pkg::TRACK_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_track_count <= i_cfg_data;
        end
    end

    // front: takes items, decodes the command, clamps the request track
    cscan_front #(
        .TRACK_BITS (TRACK_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .i_pop      (q_pop),
        .o_q_entry  (q_entry)
    );

    // back: request store, selection scan and the result register
    cscan_back #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_pop         (q_pop),
        .i_q_entry     (q_entry),
        .i_track_count (r_track_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule

>>> design/cscan_front.sv
// cscan_front: accepts input items, decodes the command and clamps the track
// pushes decoded entries into a short command queue for the back end
// depends on cscan_pkg
module cscan_front #(
    parameter int TRACK_BITS = cscan_pkg::DEF_TRACK_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cscan_pkg::t_in_item  i_in_item,
    output logic                 o_q_valid,
    input  logic                 i_pop,
    output cscan_pkg::t_q_entry  o_q_entry
);

    localparam int FW = cscan_pkg::FIELD_W;
    localparam int PW = cscan_pkg::QPTR_W;
    localparam logic [31:0] MAX_TRK_32 = (32'd1 << TRACK_BITS) - 32'd1;
    localparam logic [FW-1:0] MAX_TRK = MAX_TRK_32[FW-1:0];
    localparam logic [31:0] FULL_32 = cscan_pkg::QUEUE_DEPTH;
    localparam logic [PW:0] FULL = FULL_32[PW:0];

    cscan_pkg::t_q_entry r_queue [cscan_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       r_wr;
    logic [PW-1:0]       r_rd;
    logic [PW:0]         r_cnt;
    cscan_pkg::t_q_entry s_entry;
    logic                s_push;
    logic                s_pop;

    // classify and clamp to the track range the store can hold
    always_comb begin
        s_entry.op    = i_in_item.cmd ? cscan_pkg::OP_START : cscan_pkg::OP_LOAD;
        s_entry.track = (i_in_item.request_track > MAX_TRK) ? MAX_TRK
                                                            : i_in_item.request_track;
        s_entry.head  = i_in_item.head_position;
        s_entry.prev  = i_in_item.previous_position;
    end

    assign o_in_stall = (r_cnt == FULL);
    assign o_q_valid  = (r_cnt != '0);
    assign s_push     = i_in_valid && !o_in_stall;
    assign s_pop      = i_pop && o_q_valid;
    assign o_q_entry  = r_queue[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (s_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!s_push && s_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_queue[r_wr] <= s_entry;
        end
    end

endmodule

>>> design/cscan_back.sv
// cscan_back: request store and c-scan selection engine
// executes load and start entries from the queue, drives the result register
// depends on cscan_pkg
module cscan_back #(
    parameter int MAX_REQUESTS = cscan_pkg::DEF_MAX_REQUESTS,
    parameter int TRACK_BITS   = cscan_pkg::DEF_TRACK_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_pop,
    input  cscan_pkg::t_q_entry           i_q_entry,
    input  logic [cscan_pkg::CFG_W-1:0]   i_track_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cscan_pkg::t_out_item          o_out_item
);

    localparam int FW    = cscan_pkg::FIELD_W;
    localparam int SW    = cscan_pkg::SEEK_W;
    localparam int CW    = cscan_pkg::CFG_W;
    localparam int TB    = TRACK_BITS;
    localparam int KEY_W = TB + 1;
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam logic [31:0] TC_MAX_32 = 32'd1 << TRACK_BITS;
    localparam logic [CW-1:0] TC_MAX = TC_MAX_32[CW-1:0];
    localparam logic [31:0] MAX_32 = MAX_REQUESTS;
    localparam logic [CNT_W-1:0] CNT_MAX = MAX_32[CNT_W-1:0];

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;

    logic [TB-1:0]      r_mem [MAX_REQUESTS];
    logic [TB-1:0]      r_rdata;
    logic [CNT_W-1:0]   r_count;
    logic               r_overflow;
    logic [MAX_REQUESTS-1:0] r_used;

    // run context
    logic [TB-1:0]      r_top;
    logic [TB-1:0]      r_head;
    logic [TB-1:0]      r_base;
    logic               r_up;

    // scan pipeline
    logic [CNT_W-1:0]   r_issue;
    logic               r_cmp_valid;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [CNT_W-1:0]   r_emit_k;
    logic               r_have_best;
    logic [KEY_W-1:0]   r_best_key;
    logic [TB-1:0]      r_best_v;
    logic [IDX_W-1:0]   r_best_idx;

    logic                  r_out_valid;
    cscan_pkg::t_out_item  r_out_item;

    logic [CW-1:0]  s_tc_lim;
    logic [CW-1:0]  s_tc_m1;
    logic [TB-1:0]  s_top;
    logic [FW-1:0]  s_top_f;
    logic [TB-1:0]  s_head;
    logic [TB-1:0]  s_prev;
    logic           s_up;
    logic           s_load_ok;
    logic           s_is_load;
    logic           s_issue_ok;
    logic           s_scan_done;
    logic           s_last;
    logic [TB-1:0]  s_v;
    logic           s_flag;
    logic [KEY_W-1:0] s_key;
    logic           s_take;
    logic [TB-1:0]  s_add;
    logic [TB:0]    s_seek;

    // run setup from the start entry: top track and clamped head positions
    always_comb begin
        s_tc_lim = (i_track_count > TC_MAX) ? TC_MAX : i_track_count;
        s_tc_m1  = s_tc_lim - 1'b1;
        s_top    = (i_track_count == '0) ? '0 : s_tc_m1[TB-1:0];
        s_top_f  = FW'(s_top);
        s_head   = (i_q_entry.head > s_top_f) ? s_top : i_q_entry.head[TB-1:0];
        s_prev   = (i_q_entry.prev > s_top_f) ? s_top : i_q_entry.prev[TB-1:0];
        s_up     = (s_prev < s_head);
    end

    assign s_load_ok = !r_out_valid || !i_out_stall;
    assign s_is_load = (i_q_entry.op == cscan_pkg::OP_LOAD);

    always_comb begin
        o_pop = 1'b0;
        if (r_state == S_IDLE && i_q_valid) begin
            o_pop = s_is_load || s_load_ok;
        end
    end

    // key ordering: serving side first, then the far side after the wrap;
    // upward ascends, downward descends (inverted value)
    always_comb begin
        s_v    = (r_rdata > r_top) ? r_top : r_rdata;
        s_flag = r_up ? (s_v < r_head) : (s_v > r_head);
        s_key  = {s_flag, (r_up ? s_v : ~s_v)};
        s_take = r_cmp_valid && !r_used[r_cmp_idx]
                 && (!r_have_best || s_key < r_best_key);
    end

    assign s_issue_ok  = (r_issue < r_count);
    assign s_scan_done = !s_issue_ok && !r_cmp_valid;
    assign s_last      = (r_emit_k == r_count - 1'b1);

    // total seek closes on the last pick: it is the far-side extreme when
    // that side held requests, otherwise only the run to the end track
    always_comb begin
        if (!r_best_key[KEY_W-1]) begin
            s_add = '0;
        end else if (r_up) begin
            s_add = r_best_v;
        end else begin
            s_add = r_top - r_best_v;
        end
        s_seek = {1'b0, r_base} + {1'b0, s_add};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_have_best <= 1'b0;
            r_issue     <= '0;
            r_emit_k    <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (s_is_load) begin
                            if (r_count < CNT_MAX) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_overflow <= 1'b1;
                            end
                        end else if (r_count == '0) begin
                            r_out_valid <= 1'b1;
                            r_overflow  <= 1'b0;
                        end else begin
                            r_state     <= S_SCAN;
                            r_issue     <= '0;
                            r_emit_k    <= '0;
                            r_have_best <= 1'b0;
                            r_cmp_valid <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_valid <= s_issue_ok;
                    if (s_issue_ok) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (s_take) begin
                        r_have_best <= 1'b1;
                    end
                    if (s_scan_done && s_load_ok) begin
                        r_out_valid <= 1'b1;
                        if (s_last) begin
                            r_state    <= S_IDLE;
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                        end else begin
                            r_emit_k    <= r_emit_k + 1'b1;
                            r_issue     <= '0;
                            r_have_best <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_pop) begin
            if (s_is_load) begin
                if (r_count < CNT_MAX) begin
                    r_mem[r_count[IDX_W-1:0]] <= i_q_entry.track[TB-1:0];
                end
            end else begin
                r_top  <= s_top;
                r_head <= s_head;
                r_up   <= s_up;
                r_base <= s_up ? (s_top - s_head) : s_head;
                r_used <= '0;
                if (r_count == '0) begin
                    r_out_item.served_track <= '0;
                    r_out_item.total_seek   <= '0;
                    r_out_item.is_last      <= 1'b1;
                    r_out_item.is_empty     <= 1'b1;
                    r_out_item.overflowed   <= r_overflow;
                end
            end
        end
        r_rdata   <= r_mem[r_issue[IDX_W-1:0]];
        r_cmp_idx <= r_issue[IDX_W-1:0];
        if (r_state == S_SCAN) begin
            if (s_take) begin
                r_best_key <= s_key;
                r_best_v   <= s_v;
                r_best_idx <= r_cmp_idx;
            end
            if (s_scan_done && s_load_ok) begin
                r_used[r_best_idx]      <= 1'b1;
                r_out_item.served_track <= FW'(r_best_v);
                r_out_item.total_seek   <= s_last ? SW'(s_seek) : '0;
                r_out_item.is_last      <= s_last;
                r_out_item.is_empty     <= 1'b0;
                r_out_item.overflowed   <= r_overflow;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("request count beyond capacity");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_emit_k < r_count))
        else $error("emit index past stored requests");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && s_scan_done) |-> r_have_best)
        else $error("scan finished without an unserved request");

    a_run_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && s_scan_done && s_load_ok && s_last)
        |=> (r_state == S_IDLE && r_count == '0 && !r_overflow && r_out_valid))
        else $error("run did not close after last result");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.is_empty) |-> r_out_item.is_last)
        else $error("empty result not marked last");

endmodule
